/* hdl/signed_int_to_decimal_text_assert.svh */
// Assertion macros shared by the decimal text converter RTL.
// Each macro checks on the rising edge of clock and is off while reset is high.
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_ASSERT_SVH

// Same-cycle implication.
`define SITDT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed in decimal text converter");

// Next-cycle implication.
`define SITDT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed in decimal text converter");

`endif

/* hdl/sitdt_pkg.sv */
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies.
package sitdt_pkg;

   localparam int CHAR_WIDTH   = 6;
   localparam int LENGTH_WIDTH = 4;

   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 6'd45;
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 6'd48;

   // Commands from the sequencer to the conversion unit.
   typedef struct packed {
      logic load;
      logic shift;
   } ctrl_type;

endpackage

/* hdl/sitdt_ifs.sv */
// Valid/ready channel interfaces for the decimal text converter.
// Depends on sitdt_pkg for the result field widths.
interface sitdt_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitdt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [sitdt_pkg::CHAR_WIDTH-1:0]     character;
   logic [sitdt_pkg::LENGTH_WIDTH-1:0]   text_length;
   logic                                 is_last;

   modport source (output valid, output character, output text_length, output is_last,
                   input ready);
   modport sink   (input valid, input character, input text_length, input is_last,
                   output ready);
endinterface

/* hdl/sitdt_bcd_unit.sv */
// Shift-and-add-3 binary to BCD unit with a running significant digit count.
// Depends on sitdt_pkg for the control struct.
module sitdt_bcd_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  sitdt_pkg::ctrl_type           ctrl,
   input  logic [VALUE_WIDTH-1:0]        magnitude,
   input  logic [$clog2(VALUE_WIDTH*30103/100000+1)-1:0] rd_idx,
   output logic [3:0]                    digit,
   output logic [$clog2(VALUE_WIDTH*30103/100000+2)-1:0] ndig
);

   localparam int DIGITS = VALUE_WIDTH * 30103 / 100000 + 1;
   localparam int IDX_W  = $clog2(DIGITS);
   localparam int CNT_W  = $clog2(DIGITS + 1);

   logic [VALUE_WIDTH-1:0] bin_ff;
   logic [3:0]             bcd_ff [DIGITS];
   logic [CNT_W-1:0]       ndig_ff;

   logic [3:0] adj     [DIGITS];
   logic [3:0] shifted [DIGITS];
   logic       carry   [DIGITS];
   logic       next_nz;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      carry[0] = bin_ff[VALUE_WIDTH-1];
      for (int i = 1; i < DIGITS; i++) begin
         carry[i] = adj[i-1][3];
      end
      for (int i = 0; i < DIGITS; i++) begin
         shifted[i] = {adj[i][2:0], carry[i]};
      end
      // A shift at most doubles the value, so only the nibble just above the
      // current top digit can become significant.
      next_nz = (ndig_ff < CNT_W'(DIGITS)) && (shifted[ndig_ff[IDX_W-1:0]] != 4'd0);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         bin_ff  <= magnitude;
         ndig_ff <= CNT_W'(1);
         for (int i = 0; i < DIGITS; i++) begin
            bcd_ff[i] <= 4'd0;
         end
      end else if (ctrl.shift) begin
         bin_ff  <= {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         ndig_ff <= ndig_ff + CNT_W'(next_nz);
         for (int i = 0; i < DIGITS; i++) begin
            bcd_ff[i] <= shifted[i];
         end
      end
   end

   assign digit = bcd_ff[rd_idx];
   assign ndig  = ndig_ff;

endmodule

/* hdl/signed_int_to_decimal_text.sv */
// Top level of the signed integer to decimal text converter: sequencer and result register.
// Depends on sitdt_pkg, sitdt_ifs and sitdt_bcd_unit.
//
//   Channel   Direction  Handshake               Payload
//   req_if    in         valid/ready             value (VALUE_WIDTH, signed)
//   rsp_if    out        valid/ready             character, text_length, is_last
//
// Each value is accepted, shifted through the BCD unit once per magnitude bit, set up, and then
// sent one character per cycle while the result side does not stall (1 to 11 characters at the
// default width).
// Reset is synchronous and active high; it clears the sequencer and the result valid.
// A stalled result holds in the output register; a new value is accepted as soon as
// the last character of the previous one has been loaded there.
module signed_int_to_decimal_text #(
   parameter int VALUE_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   sitdt_req_if.sink   req_if,
   sitdt_rsp_if.source rsp_if
);

`include "signed_int_to_decimal_text_assert.svh"

   localparam int DIGITS = VALUE_WIDTH * 30103 / 100000 + 1;
   localparam int IDX_W  = $clog2(DIGITS);
   localparam int CNT_W  = $clog2(DIGITS + 1);
   localparam int SH_W   = $clog2(VALUE_WIDTH);
   localparam int LEN_W  = (CNT_W + 1 > sitdt_pkg::LENGTH_WIDTH) ? CNT_W + 1
                                                                 : sitdt_pkg::LENGTH_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SETUP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic                                neg_ff, neg_in;
   logic                                sign_pend_ff, sign_pend_in;
   logic [IDX_W-1:0]                    pos_ff, pos_in;
   logic [SH_W-1:0]                     sh_cnt_ff, sh_cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sitdt_pkg::CHAR_WIDTH-1:0]    char_ff, char_in;
   logic [sitdt_pkg::LENGTH_WIDTH-1:0]  len_ff, len_in;
   logic                                last_ff, last_in;

   sitdt_pkg::ctrl_type    ctrl;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic [3:0]             digit;
   logic [CNT_W-1:0]       ndig;
   logic [CNT_W-1:0]       ndig_dec;
   logic [LEN_W-1:0]       len_sum;
   logic                   req_take;
   logic                   out_free;
   logic                   emit_last;
   logic                   minus_out;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   // The output slot can take a new transfer when empty or when being drained.
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // Two's complement magnitude; the most negative value maps onto the top bit alone,
   // which the unsigned interpretation reads correctly.
   assign magnitude = req_if.value[VALUE_WIDTH-1] ? (~req_if.value + VALUE_WIDTH'(1))
                                                  : req_if.value;

   assign ctrl.load  = req_take;
   assign ctrl.shift = (state_ff == ST_CONVERT);

   sitdt_bcd_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_bcd (
      .clock     (clock),
      .ctrl      (ctrl),
      .magnitude (magnitude),
      .rd_idx    (pos_ff),
      .digit     (digit),
      .ndig      (ndig)
   );

   assign ndig_dec = ndig - CNT_W'(1);
   assign len_sum  = LEN_W'(ndig) + LEN_W'(neg_ff);

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      sign_pend_in = sign_pend_ff;
      pos_in       = pos_ff;
      sh_cnt_in    = sh_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      char_in      = char_ff;
      len_in       = len_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_in    = req_if.value[VALUE_WIDTH-1];
               sh_cnt_in = '0;
               state_in  = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            sh_cnt_in = sh_cnt_ff + SH_W'(1);
            if (sh_cnt_ff == SH_W'(VALUE_WIDTH - 1)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // The digit count is final here; start from the most significant digit.
            pos_in       = ndig_dec[IDX_W-1:0];
            sign_pend_in = neg_ff;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               len_in       = len_sum[sitdt_pkg::LENGTH_WIDTH-1:0];
               if (sign_pend_ff) begin
                  char_in      = sitdt_pkg::ASCII_MINUS;
                  last_in      = 1'b0;
                  sign_pend_in = 1'b0;
               end else begin
                  char_in = sitdt_pkg::ASCII_ZERO + sitdt_pkg::CHAR_WIDTH'(digit);
                  last_in = (pos_ff == '0);
                  if (pos_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     pos_in = pos_ff - IDX_W'(1);
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff       <= neg_in;
      sign_pend_ff <= sign_pend_in;
      pos_ff       <= pos_in;
      sh_cnt_ff    <= sh_cnt_in;
      char_ff      <= char_in;
      len_ff       <= len_in;
      last_ff      <= last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.character   = char_ff;
   assign rsp_if.text_length = len_ff;
   assign rsp_if.is_last     = last_ff;

   assign emit_last = (state_ff == ST_EMIT) && out_free && !sign_pend_ff && (pos_ff == '0);
   assign minus_out = rsp_if.valid && (rsp_if.character == sitdt_pkg::ASCII_MINUS);

   // Loading the least significant digit ends the item and frees the input side.
   `SITDT_ASSERT_NEXT(a_last_digit_to_idle, emit_last, state_ff == ST_IDLE && rsp_valid_ff && last_ff)
   // A minus sign always precedes at least one digit.
   `SITDT_ASSERT_NOW(a_minus_not_last, minus_out, !rsp_if.is_last)
   // The significant digit count stays within the BCD register while characters go out.
   `SITDT_ASSERT_NOW(a_ndig_range, state_ff == ST_EMIT, (ndig != '0) && (ndig <= CNT_W'(DIGITS)))
   // The digit being read never lies above the most significant digit.
   `SITDT_ASSERT_NOW(a_pos_range, state_ff == ST_EMIT, CNT_W'(pos_ff) < ndig)

endmodule
